@@ hw/rtl/track_straightness_classifier_core_assert.svh @@
// Assertion macros shared by the track straightness classifier RTL.
// Checks compile only when SYNTHESIS is not defined.
`ifndef TRACK_STRAIGHTNESS_CLASSIFIER_CORE_ASSERT_SVH
`define TRACK_STRAIGHTNESS_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define TSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Condition never occurs outside reset.
`define TSC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define TSC_ASSERT(lbl, clk, rst_n, prop)

`define TSC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/tsc_pkg.sv @@
// Shared types and constants of the track straightness classifier.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

    // Field widths
    localparam int CENTRE_W = 7;
    localparam int TOP_W    = 6;
    localparam int STEER_W  = 8;
    localparam int LOOK_W   = 6;
    localparam int SUM_W    = 12;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int PERIOD_W = 4;

    // Row index arithmetic is done at this width (covers up to 512 rows)
    localparam int IDX_W = 9;

    // Unsigned divider width and its step counter
    localparam int DIV_W     = 8;
    localparam int DIV_CNT_W = 3;

    // Quotient tracker width: |diff * (i - end)| stays below 2^15
    localparam int Q_W = 16;

    // floor(x * 171 / 512) == floor(x / 3) for x < 512
    localparam logic [IDX_W-1:0] RECIP3 = 9'd171;

    localparam logic [CENTRE_W-1:0] CHORD_MIN = 7'd1;
    localparam logic [CENTRE_W-1:0] CHORD_MAX = 7'd79;
    localparam logic [SUM_W-1:0]    SUM_MAX   = 12'd4095;
    localparam int HIST_DEPTH = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORESIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD         = 3'd4;

    // Configuration reset values
    localparam logic [STEER_W-1:0]  RST_ERROR_LIMIT    = 8'd5;
    localparam logic [SUM_W-1:0]    RST_STRAIGHT_LIMIT = 12'd30;
    localparam logic [TOP_W-1:0]    RST_TOP_LIMIT      = 6'd25;
    localparam logic [LOOK_W-1:0]   RST_FORESIGHT      = 6'd5;
    localparam logic [PERIOD_W-1:0] RST_PERIOD         = 4'd5;

    typedef enum logic [1:0] {
        CLS_CURVE_TO_STRAIGHT = 2'd0,
        CLS_STRAIGHT          = 2'd1,
        CLS_STRAIGHT_TO_CURVE = 2'd2,
        CLS_IN_CURVE          = 2'd3
    } t_track_class;

    typedef enum logic [3:0] {
        S_IDLE,
        S_END,
        S_RD,
        S_LD,
        S_DIV,
        S_FIX,
        S_FETCH,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_row;     // non-last row transfer
        logic ld_frame;   // last row transfer
        logic calc_end;   // derive far row and divisor
        logic ld_end;     // capture far centre, arm divider
        logic div_step;   // one restoring division step
        logic fix;        // turn quotient into floor form
        logic fetch;      // read centre of current row, register chord
        logic step;       // accumulate and move two rows up
        logic out_load;   // load result register
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic more;
        logic more_next;
        logic out_valid;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hw/rtl/track_straightness_classifier_core.sv @@
// Track straightness classifier: a row that is not the last is taken every cycle
// (one store write). The last row starts a frame-end sequence that ends when the result
// is valid: far-row lookup, a restoring division, then one store read per summed row
// (at most ROWS/2 summed rows). No row is taken during that sequence. Synchronous
// active-low reset clears control, history and counters and restores register defaults;
// the centre store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module track_straightness_classifier_core #(
    parameter int ROWS = 60
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [tsc_pkg::CENTRE_W-1:0]  i_centre_column,
    input  wire logic                          i_last_row,
    input  wire logic [tsc_pkg::TOP_W-1:0]     i_top_row,
    input  wire logic [tsc_pkg::STEER_W-1:0]   i_steer_error,
    input  wire logic [tsc_pkg::LOOK_W-1:0]    i_lookahead,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [tsc_pkg::SUM_W-1:0]     o_deviation_sum,
    output logic      [1:0]                    o_track_class,
    input  wire logic                          i_cfg_we,
    input  wire logic [tsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tsc_pkg::CFG_W-1:0]     i_cfg_data
);

    tsc_pkg::t_dp_cmd  cmd;
    tsc_pkg::t_dp_stat stat;

    tsc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_last_row(i_last_row),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    tsc_datapath #(
        .ROWS(ROWS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_centre_column(i_centre_column),
        .i_top_row      (i_top_row),
        .i_steer_error  (i_steer_error),
        .i_lookahead    (i_lookahead),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_deviation_sum(o_deviation_sum),
        .o_track_class  (o_track_class)
    );

    assign o_out_valid = stat.out_valid;

endmodule

`default_nettype wire

@@ hw/rtl/tsc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tsc_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 60
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/tsc_ctrl.sv @@
// Frame-end sequencer of the track straightness classifier.
// Depends on tsc_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "track_straightness_classifier_core_assert.svh"

module tsc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_last_row,
    output logic                   o_in_ready,
    input  wire tsc_pkg::t_dp_stat i_stat,
    output tsc_pkg::t_dp_cmd       o_cmd
);

    tsc_pkg::t_state r_state;
    tsc_pkg::t_state n_state;
    logic            accept;

    // A last row needs a free result register; plain rows only fill the store.
    assign o_in_ready = (r_state == tsc_pkg::S_IDLE) && (!i_last_row || !i_stat.out_valid);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsc_pkg::S_IDLE: begin
                if (accept && i_last_row) begin
                    n_state = tsc_pkg::S_END;
                end
            end
            tsc_pkg::S_END:   n_state = tsc_pkg::S_RD;
            tsc_pkg::S_RD:    n_state = tsc_pkg::S_LD;
            tsc_pkg::S_LD:    n_state = tsc_pkg::S_DIV;
            tsc_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = tsc_pkg::S_FIX;
                end
            end
            tsc_pkg::S_FIX: begin
                n_state = i_stat.more ? tsc_pkg::S_FETCH : tsc_pkg::S_DONE;
            end
            tsc_pkg::S_FETCH: n_state = tsc_pkg::S_ACC;
            tsc_pkg::S_ACC: begin
                n_state = i_stat.more_next ? tsc_pkg::S_FETCH : tsc_pkg::S_DONE;
            end
            tsc_pkg::S_DONE:  n_state = tsc_pkg::S_IDLE;
            default:          n_state = tsc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tsc_pkg::S_IDLE: begin
                o_cmd.wr_row   = accept && !i_last_row;
                o_cmd.ld_frame = accept && i_last_row;
            end
            tsc_pkg::S_END:   o_cmd.calc_end = 1'b1;
            tsc_pkg::S_RD:    ;
            tsc_pkg::S_LD:    o_cmd.ld_end   = 1'b1;
            tsc_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            tsc_pkg::S_FIX:   o_cmd.fix      = 1'b1;
            tsc_pkg::S_FETCH: o_cmd.fetch    = 1'b1;
            tsc_pkg::S_ACC:   o_cmd.step     = 1'b1;
            tsc_pkg::S_DONE:  o_cmd.out_load = 1'b1;
            default:          o_cmd = '0;
        endcase
    end

    `TSC_ASSERT_NEVER(a_ready_only_idle, i_clk, i_rst_n, o_in_ready && (r_state != tsc_pkg::S_IDLE))
    `TSC_ASSERT(a_load_into_free_reg, i_clk, i_rst_n, o_cmd.out_load |-> !i_stat.out_valid)
    `TSC_ASSERT(a_frame_starts_seq, i_clk, i_rst_n, o_cmd.ld_frame |=> (r_state == tsc_pkg::S_END))

endmodule

`default_nettype wire

@@ hw/rtl/tsc_datapath.sv @@
// Datapath of the track straightness classifier: centre store, chord
// tracker with a restoring divider, history and result register.
// Depends on tsc_pkg, tsc_ram and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "track_straightness_classifier_core_assert.svh"

module tsc_datapath #(
    parameter int ROWS = 60
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tsc_pkg::t_dp_cmd                  i_cmd,
    output tsc_pkg::t_dp_stat                      o_stat,
    input  wire logic [tsc_pkg::CENTRE_W-1:0]      i_centre_column,
    input  wire logic [tsc_pkg::TOP_W-1:0]         i_top_row,
    input  wire logic [tsc_pkg::STEER_W-1:0]       i_steer_error,
    input  wire logic [tsc_pkg::LOOK_W-1:0]        i_lookahead,
    input  wire logic                              i_cfg_we,
    input  wire logic [tsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tsc_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                              i_out_ready,
    output logic      [tsc_pkg::SUM_W-1:0]         o_deviation_sum,
    output logic      [1:0]                        o_track_class
);

    localparam int AW = $clog2(ROWS);
    localparam logic [AW-1:0]                 LAST     = AW'(ROWS - 1);
    localparam logic [tsc_pkg::IDX_W-1:0]     LAST_X   = tsc_pkg::IDX_W'(ROWS - 1);
    localparam logic [tsc_pkg::TOP_W-1:0]     LAST_TOP = tsc_pkg::TOP_W'(ROWS - 1);
    localparam int PW = 2 * tsc_pkg::IDX_W - 1;

    // Configuration
    logic [tsc_pkg::STEER_W-1:0]  r_error_limit;
    logic [tsc_pkg::SUM_W-1:0]    r_straight_limit;
    logic [tsc_pkg::TOP_W-1:0]    r_top_limit;
    logic [tsc_pkg::LOOK_W-1:0]   r_foresight;
    logic [tsc_pkg::PERIOD_W-1:0] r_period;

    // Control state
    logic [AW-1:0]                r_row_cnt;
    logic [tsc_pkg::PERIOD_W-1:0] r_frame_cnt;
    logic [tsc_pkg::STEER_W-1:0]  r_hist [tsc_pkg::HIST_DEPTH];
    logic                         r_out_valid;

    // Frame payload
    logic [tsc_pkg::CENTRE_W-1:0] r_c_last;
    logic [tsc_pkg::CENTRE_W-1:0] r_c_end;
    logic [tsc_pkg::TOP_W-1:0]    r_top;
    logic [tsc_pkg::LOOK_W-1:0]   r_look;
    logic [AW-1:0]                r_end;
    logic [AW-1:0]                r_den;
    logic [tsc_pkg::IDX_W-1:0]    r_top2;
    logic [tsc_pkg::IDX_W-1:0]    r_i;
    logic                         r_neg;
    logic [tsc_pkg::DIV_W-1:0]    r_dq;
    logic [tsc_pkg::DIV_W-1:0]    r_drem;
    logic [tsc_pkg::DIV_CNT_W-1:0] r_dcnt;
    logic signed [tsc_pkg::Q_W-1:0] r_q;
    logic signed [tsc_pkg::Q_W-1:0] r_qd;
    logic [tsc_pkg::DIV_W-1:0]    r_r;
    logic [tsc_pkg::DIV_W-1:0]    r_rd;
    logic [tsc_pkg::CENTRE_W-1:0] r_chord;
    logic [tsc_pkg::SUM_W-1:0]    r_sum;
    logic [tsc_pkg::SUM_W-1:0]    r_out_sum;
    tsc_pkg::t_track_class        r_out_class;

    // Store port
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [tsc_pkg::CENTRE_W-1:0] ram_rdata;

    // Combinational values
    logic [tsc_pkg::PERIOD_W-1:0] n_frame_cnt;
    logic                         push;
    logic [tsc_pkg::TOP_W-1:0]    top_sat;
    logic [tsc_pkg::IDX_W-1:0]    span;
    logic [PW-1:0]                span_prod;
    logic [tsc_pkg::IDX_W-1:0]    end_raw;
    logic [tsc_pkg::IDX_W-1:0]    n_end;
    logic [tsc_pkg::DIV_W-1:0]    den8;
    logic [tsc_pkg::DIV_W-1:0]    diff;
    logic [tsc_pkg::DIV_W-1:0]    diff_mag;
    logic [tsc_pkg::DIV_W:0]      div_trial;
    logic                         div_ge;
    logic [tsc_pkg::DIV_W:0]      div_sub;
    logic [tsc_pkg::Q_W-1:0]      uq;
    logic signed [tsc_pkg::Q_W-1:0] n_qd;
    logic [tsc_pkg::DIV_W-1:0]    n_rd;
    logic signed [tsc_pkg::Q_W:0] chord_x;
    logic [tsc_pkg::CENTRE_W-1:0] n_chord;
    logic [tsc_pkg::DIV_W-1:0]    dev;
    logic [tsc_pkg::DIV_W-1:0]    dev_abs;
    logic [tsc_pkg::SUM_W:0]      sum_x;
    logic [tsc_pkg::DIV_W:0]      r_diff_x;
    logic signed [tsc_pkg::Q_W-1:0] n_q;
    logic [tsc_pkg::DIV_W-1:0]    n_r;
    logic                         all_high;
    logic                         all_low;
    tsc_pkg::t_track_class        n_class;

    tsc_ram #(
        .WIDTH(tsc_pkg::CENTRE_W),
        .DEPTH(ROWS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_centre_column),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Extra rows beyond the last slot are dropped; the last row always lands at the end.
    assign ram_we    = (i_cmd.wr_row && (r_row_cnt < LAST)) || i_cmd.ld_frame;
    assign ram_waddr = i_cmd.ld_frame ? LAST : r_row_cnt;
    assign ram_raddr = i_cmd.fetch ? r_i[AW-1:0] : r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_limit    <= tsc_pkg::RST_ERROR_LIMIT;
            r_straight_limit <= tsc_pkg::RST_STRAIGHT_LIMIT;
            r_top_limit      <= tsc_pkg::RST_TOP_LIMIT;
            r_foresight      <= tsc_pkg::RST_FORESIGHT;
            r_period         <= tsc_pkg::RST_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsc_pkg::CFG_ERROR_LIMIT:    r_error_limit    <= i_cfg_data[tsc_pkg::STEER_W-1:0];
                tsc_pkg::CFG_STRAIGHT_LIMIT: r_straight_limit <= i_cfg_data;
                tsc_pkg::CFG_TOP_LIMIT:      r_top_limit      <= i_cfg_data[tsc_pkg::TOP_W-1:0];
                tsc_pkg::CFG_FORESIGHT:      r_foresight      <= i_cfg_data[tsc_pkg::LOOK_W-1:0];
                tsc_pkg::CFG_PERIOD:         r_period         <= i_cfg_data[tsc_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // History push every period-th frame; the counter wraps at 16.
    assign n_frame_cnt = r_frame_cnt + 1'b1;
    assign push        = (n_frame_cnt == r_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt   <= '0;
            r_frame_cnt <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < tsc_pkg::HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            if (i_cmd.ld_frame) begin
                r_row_cnt   <= '0;
                r_frame_cnt <= push ? '0 : n_frame_cnt;
                if (push) begin
                    for (int k = 0; k < tsc_pkg::HIST_DEPTH - 1; k++) begin
                        r_hist[k] <= r_hist[k+1];
                    end
                    r_hist[tsc_pkg::HIST_DEPTH-1] <= i_steer_error;
                end
            end else if (i_cmd.wr_row && (r_row_cnt < LAST)) begin
                r_row_cnt <= r_row_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Far row: End = L - (L - top) / 3, moved down to odd.
    assign top_sat   = ({3'b000, i_top_row} > LAST_X) ? LAST_TOP : i_top_row;
    assign span      = LAST_X - tsc_pkg::IDX_W'(r_top);
    assign span_prod = PW'(span) * PW'(tsc_pkg::RECIP3);
    assign end_raw   = LAST_X - tsc_pkg::IDX_W'(span_prod[PW-1:tsc_pkg::IDX_W]);
    assign n_end     = end_raw[0] ? end_raw : end_raw - 1'b1;
    assign den8      = tsc_pkg::DIV_W'(r_den);

    // Slope numerator: diff = cLast - cEnd, divided as |2*diff| / den.
    assign diff     = {1'b0, r_c_last} - {1'b0, ram_rdata};
    assign diff_mag = diff[tsc_pkg::DIV_W-1] ? -diff : diff;

    // Restoring division, one quotient bit per step.
    assign div_trial = {r_drem, r_dq[tsc_pkg::DIV_W-1]};
    assign div_ge    = (div_trial >= {1'b0, den8});
    assign div_sub   = div_ge ? (div_trial - {1'b0, den8}) : div_trial;

    // Floor form of the signed quotient, remainder kept in 0..den-1.
    assign uq = tsc_pkg::Q_W'(r_dq);
    always_comb begin
        n_qd = $signed(uq);
        n_rd = r_drem;
        if (r_neg) begin
            if (r_drem == '0) begin
                n_qd = -$signed(uq);
                n_rd = '0;
            end else begin
                n_qd = $signed(~uq);
                n_rd = den8 - r_drem;
            end
        end
    end

    // Chord value of the current row, clamped to the column range.
    assign chord_x = $signed({{(tsc_pkg::Q_W + 1 - tsc_pkg::CENTRE_W){1'b0}}, r_c_end})
                   + $signed({r_q[tsc_pkg::Q_W-1], r_q});
    always_comb begin
        if (chord_x < $signed({{(tsc_pkg::Q_W + 1 - tsc_pkg::CENTRE_W){1'b0}},
                               tsc_pkg::CHORD_MIN})) begin
            n_chord = tsc_pkg::CHORD_MIN;
        end else if (chord_x > $signed({{(tsc_pkg::Q_W + 1 - tsc_pkg::CENTRE_W){1'b0}},
                                        tsc_pkg::CHORD_MAX})) begin
            n_chord = tsc_pkg::CHORD_MAX;
        end else begin
            n_chord = chord_x[tsc_pkg::CENTRE_W-1:0];
        end
    end

    // Deviation and saturating sum.
    assign dev     = {1'b0, ram_rdata} - {1'b0, r_chord};
    assign dev_abs = dev[tsc_pkg::DIV_W-1] ? -dev : dev;
    assign sum_x   = {1'b0, r_sum} + (tsc_pkg::SUM_W + 1)'(dev_abs);

    // Two rows up: numerator drops by 2*diff = qd*den + rd.
    assign r_diff_x = {1'b0, r_r} - {1'b0, r_rd};
    always_comb begin
        if (r_diff_x[tsc_pkg::DIV_W]) begin
            n_r = r_diff_x[tsc_pkg::DIV_W-1:0] + den8;
            n_q = r_q - r_qd - tsc_pkg::Q_W'(1);
        end else begin
            n_r = r_diff_x[tsc_pkg::DIV_W-1:0];
            n_q = r_q - r_qd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_frame) begin
            r_c_last <= i_centre_column;
            r_top    <= top_sat;
            r_look   <= i_lookahead;
        end
        if (i_cmd.calc_end) begin
            r_end  <= n_end[AW-1:0];
            r_den  <= LAST - n_end[AW-1:0];
            r_top2 <= tsc_pkg::IDX_W'(r_top) + tsc_pkg::IDX_W'(2);
        end
        if (i_cmd.ld_end) begin
            r_c_end <= ram_rdata;
            r_neg   <= diff[tsc_pkg::DIV_W-1];
            r_dq    <= {diff_mag[tsc_pkg::DIV_W-2:0], 1'b0};
            r_drem  <= '0;
            r_dcnt  <= '0;
            r_i     <= LAST_X;
            r_q     <= tsc_pkg::Q_W'($signed(diff));
            r_r     <= '0;
            r_sum   <= '0;
        end
        if (i_cmd.div_step) begin
            r_drem <= div_sub[tsc_pkg::DIV_W-1:0];
            r_dq   <= {r_dq[tsc_pkg::DIV_W-2:0], div_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.fix) begin
            r_qd <= n_qd;
            r_rd <= n_rd;
        end
        if (i_cmd.fetch) begin
            r_chord <= n_chord;
        end
        if (i_cmd.step) begin
            r_sum <= (sum_x > {1'b0, tsc_pkg::SUM_MAX}) ? tsc_pkg::SUM_MAX
                                                        : sum_x[tsc_pkg::SUM_W-1:0];
            r_q   <= n_q;
            r_r   <= n_r;
            r_i   <= r_i - tsc_pkg::IDX_W'(2);
        end
        if (i_cmd.out_load) begin
            r_out_sum   <= r_sum;
            r_out_class <= n_class;
        end
    end

    // Classification from the three oldest history entries.
    assign all_high = (r_hist[0] > r_error_limit) && (r_hist[1] > r_error_limit)
                   && (r_hist[2] > r_error_limit);
    assign all_low  = (r_hist[0] < r_error_limit) && (r_hist[1] < r_error_limit)
                   && (r_hist[2] < r_error_limit);

    always_comb begin
        priority if (all_high && (r_sum < r_straight_limit) && (r_top < r_top_limit)) begin
            n_class = tsc_pkg::CLS_CURVE_TO_STRAIGHT;
        end else if (all_low && (r_look <= r_foresight)) begin
            n_class = tsc_pkg::CLS_STRAIGHT;
        end else if (all_low) begin
            n_class = tsc_pkg::CLS_STRAIGHT_TO_CURVE;
        end else begin
            n_class = tsc_pkg::CLS_IN_CURVE;
        end
    end

    // No rows qualify when the far row is the last row.
    assign o_stat.div_done  = (r_dcnt == tsc_pkg::DIV_CNT_W'(tsc_pkg::DIV_W - 1));
    assign o_stat.more      = (r_den != '0) && (r_i > r_top2);
    assign o_stat.more_next = ((r_i - tsc_pkg::IDX_W'(2)) > r_top2);
    assign o_stat.out_valid = r_out_valid;

    assign o_deviation_sum = r_out_sum;
    assign o_track_class   = r_out_class;

    `TSC_ASSERT_NEVER(a_row_cnt_range, i_clk, i_rst_n, r_row_cnt > LAST)
    `TSC_ASSERT(a_rem_below_den, i_clk, i_rst_n, (i_cmd.step && (r_den != '0)) |-> (r_r < den8))
    `TSC_ASSERT(a_out_hold, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |=> r_out_valid)

endmodule

`default_nettype wire

@@ verif/track_straightness_classifier_checker.sv @@
// Checker for the track straightness classifier: watches the row, result and register ports,
// predicts each frame's deviation sum and track class, and compares results in order.
// Depends on tsc_pkg for widths, register indexes and the track class codes.
`timescale 1ns / 1ps

module track_straightness_classifier_checker #(
    parameter int NUM_ROWS = 60
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [tsc_pkg::CENTRE_W-1:0]  i_centre_column,
    input  logic                          i_last_row,
    input  logic [tsc_pkg::TOP_W-1:0]     i_top_row,
    input  logic [tsc_pkg::STEER_W-1:0]   i_steer_error,
    input  logic [tsc_pkg::LOOK_W-1:0]    i_lookahead,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [tsc_pkg::SUM_W-1:0]     i_deviation_sum,
    input  logic [1:0]                    i_track_class,
    input  logic                          i_cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tsc_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count
);

    localparam int LAST_ROW   = NUM_ROWS - 1;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [tsc_pkg::SUM_W-1:0] sum;
        tsc_pkg::t_track_class     cls;
    } t_frame_result;

    logic [tsc_pkg::CENTRE_W-1:0] centre_mem [NUM_ROWS];
    logic [tsc_pkg::STEER_W-1:0]  err_hist [tsc_pkg::HIST_DEPTH];
    logic [tsc_pkg::PERIOD_W-1:0] frame_cnt;
    int                           row_cnt;

    logic [tsc_pkg::STEER_W-1:0]  lim_error;
    logic [tsc_pkg::SUM_W-1:0]    lim_straight;
    logic [tsc_pkg::TOP_W-1:0]    lim_top;
    logic [tsc_pkg::LOOK_W-1:0]   lim_foresight;
    logic [tsc_pkg::PERIOD_W-1:0] hist_period;

    t_frame_result expected_frames [$];
    int            mismatches = 0;

    // Sum of |centre - chord| over every second row from the last one down, above row top+2.
    function automatic int chord_deviation_sum(int top);
        int far_row;
        int c_far;
        int c_last;
        int span;
        int row;
        int prod;
        int chord;
        int dev;
        int acc;
        far_row = LAST_ROW - (LAST_ROW - top) / 3;
        if (far_row % 2 == 0) begin
            far_row = far_row - 1;
        end
        if (far_row < 0) begin
            far_row = 0;
        end
        c_far  = int'(centre_mem[far_row]);
        c_last = int'(centre_mem[LAST_ROW]);
        span   = LAST_ROW - far_row;
        acc    = 0;
        for (row = LAST_ROW; row > top + 2 && span > 0; row -= 2) begin
            prod  = (c_last - c_far) * (row - far_row);
            chord = prod / span;
            // round toward minus infinity, not toward zero
            if (prod % span != 0 && prod < 0) begin
                chord = chord - 1;
            end
            chord = c_far + chord;
            if (chord < int'(tsc_pkg::CHORD_MIN)) begin
                chord = int'(tsc_pkg::CHORD_MIN);
            end
            if (chord > int'(tsc_pkg::CHORD_MAX)) begin
                chord = int'(tsc_pkg::CHORD_MAX);
            end
            dev = int'(centre_mem[row]) - chord;
            if (dev < 0) begin
                dev = -dev;
            end
            acc = acc + dev;
            if (acc > int'(tsc_pkg::SUM_MAX)) begin
                acc = int'(tsc_pkg::SUM_MAX);
            end
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin : predict_and_check
        t_frame_result         exp_res;
        int                    top;
        int                    sum;
        int                    k;
        logic                  all_high;
        logic                  all_low;
        tsc_pkg::t_track_class cls;

        if (!i_rst_n) begin
            for (k = 0; k < NUM_ROWS; k++) begin
                centre_mem[k] = '0;
            end
            for (k = 0; k < tsc_pkg::HIST_DEPTH; k++) begin
                err_hist[k] = '0;
            end
            frame_cnt     = '0;
            row_cnt       = 0;
            lim_error     = tsc_pkg::RST_ERROR_LIMIT;
            lim_straight  = tsc_pkg::RST_STRAIGHT_LIMIT;
            lim_top       = tsc_pkg::RST_TOP_LIMIT;
            lim_foresight = tsc_pkg::RST_FORESIGHT;
            hist_period   = tsc_pkg::RST_PERIOD;
            expected_frames.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tsc_pkg::CFG_ERROR_LIMIT:
                        lim_error     = i_cfg_data[tsc_pkg::STEER_W-1:0];
                    tsc_pkg::CFG_STRAIGHT_LIMIT:
                        lim_straight  = i_cfg_data[tsc_pkg::SUM_W-1:0];
                    tsc_pkg::CFG_TOP_LIMIT:
                        lim_top       = i_cfg_data[tsc_pkg::TOP_W-1:0];
                    tsc_pkg::CFG_FORESIGHT:
                        lim_foresight = i_cfg_data[tsc_pkg::LOOK_W-1:0];
                    tsc_pkg::CFG_PERIOD:
                        hist_period   = i_cfg_data[tsc_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT) begin
                        $display("%0t: result with no frame pending: sum %0d class %0d",
                                 $realtime, i_deviation_sum, i_track_class);
                    end
                end else begin
                    exp_res = expected_frames.pop_front();
                    if (i_deviation_sum !== exp_res.sum || i_track_class !== exp_res.cls) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORT) begin
                            $display("%0t: expected sum %0d class %0d, got sum %0d class %0d",
                                     $realtime, exp_res.sum, exp_res.cls,
                                     i_deviation_sum, i_track_class);
                        end
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (!i_last_row) begin
                    // drop rows beyond the store, the last row owns the top entry
                    if (row_cnt < LAST_ROW) begin
                        centre_mem[row_cnt] = i_centre_column;
                        row_cnt++;
                    end
                end else begin
                    centre_mem[LAST_ROW] = i_centre_column;
                    row_cnt = 0;
                    top = int'(i_top_row);
                    if (top > LAST_ROW) begin
                        top = LAST_ROW;
                    end
                    sum = chord_deviation_sum(top);

                    frame_cnt = frame_cnt + 1'b1;
                    if (frame_cnt == hist_period) begin
                        frame_cnt = '0;
                        for (k = 0; k < tsc_pkg::HIST_DEPTH - 1; k++) begin
                            err_hist[k] = err_hist[k + 1];
                        end
                        err_hist[tsc_pkg::HIST_DEPTH - 1] = i_steer_error;
                    end

                    all_high = err_hist[0] > lim_error && err_hist[1] > lim_error
                            && err_hist[2] > lim_error;
                    all_low  = err_hist[0] < lim_error && err_hist[1] < lim_error
                            && err_hist[2] < lim_error;

                    if (all_high && sum < int'(lim_straight) && top < int'(lim_top)) begin
                        cls = tsc_pkg::CLS_CURVE_TO_STRAIGHT;
                    end else if (all_low && i_lookahead <= lim_foresight) begin
                        cls = tsc_pkg::CLS_STRAIGHT;
                    end else if (all_low) begin
                        cls = tsc_pkg::CLS_STRAIGHT_TO_CURVE;
                    end else begin
                        cls = tsc_pkg::CLS_IN_CURVE;
                    end

                    exp_res.sum = sum[tsc_pkg::SUM_W-1:0];
                    exp_res.cls = cls;
                    expected_frames.push_back(exp_res);
                end
            end
        end

        o_pending    <= expected_frames.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ verif/tb_track_straightness_classifier_core.sv @@
// Testbench top for track_straightness_classifier_core: drives frames of rows and register
// writes under several idle and stall patterns; the checker module predicts and compares.
// Depends on tsc_pkg, the core RTL and track_straightness_classifier_checker.
`timescale 1ns / 1ps

module tb_track_straightness_classifier_core;

    localparam int NUM_ROWS         = 60;
    localparam int CLK_PERIOD       = 12;
    localparam int TAIL_CYCLES      = 100;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int MAX_GAP          = 40;
    localparam int RUN_LIMIT_CYCLES = 1_000_000;
    localparam int ITEM_TARGET      = 1750;
    localparam int FRAME_TARGET     = 40;
    localparam int FRAMES_PER_PHASE = 6;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [tsc_pkg::CENTRE_W-1:0]  centre;
    logic                          last_row;
    logic [tsc_pkg::TOP_W-1:0]     top_row;
    logic [tsc_pkg::STEER_W-1:0]   steer;
    logic [tsc_pkg::LOOK_W-1:0]    look;
    logic                          out_valid;
    logic                          out_ready;
    logic [tsc_pkg::SUM_W-1:0]     dev_sum;
    logic [1:0]                    track_class;
    logic                          cfg_we;
    logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tsc_pkg::CFG_W-1:0]     cfg_data;

    int chk_pending;
    int chk_fails;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off_req   = 1'b0;
    int items_sent     = 0;
    int frames_sent    = 0;
    int err_limit_now  = int'(tsc_pkg::RST_ERROR_LIMIT);
    bit steer_high     = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    track_straightness_classifier_core #(
        .ROWS(NUM_ROWS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_centre_column (centre),
        .i_last_row      (last_row),
        .i_top_row       (top_row),
        .i_steer_error   (steer),
        .i_lookahead     (look),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_deviation_sum (dev_sum),
        .o_track_class   (track_class),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    track_straightness_classifier_checker #(
        .NUM_ROWS(NUM_ROWS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_centre_column (centre),
        .i_last_row      (last_row),
        .i_top_row       (top_row),
        .i_steer_error   (steer),
        .i_lookahead     (look),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_deviation_sum (dev_sum),
        .i_track_class   (track_class),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_pending       (chk_pending),
        .o_fail_count    (chk_fails)
    );

    // Result side: random stalls, or one long hold-off on request.
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one row after an optional idle gap and hold it until the transfer.
    task automatic send_row(input logic [tsc_pkg::CENTRE_W-1:0] col, input logic is_last,
                            input logic [tsc_pkg::TOP_W-1:0] top_in,
                            input logic [tsc_pkg::STEER_W-1:0] err_in,
                            input logic [tsc_pkg::LOOK_W-1:0] look_in);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        centre   <= col;
        last_row <= is_last;
        top_row  <= top_in;
        steer    <= err_in;
        look     <= look_in;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        items_sent++;
        if (is_last) begin
            frames_sent++;
        end
    endtask

    // Stop offering, wait for every pending frame result, then let the core settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Write all five registers; unused upper data bits carry random junk.
    task automatic program_regs(input logic [tsc_pkg::STEER_W-1:0] el,
                                input logic [tsc_pkg::SUM_W-1:0] sl,
                                input logic [tsc_pkg::TOP_W-1:0] tl,
                                input logic [tsc_pkg::LOOK_W-1:0] fl,
                                input logic [tsc_pkg::PERIOD_W-1:0] per);
        cfg_we    <= 1'b1;
        cfg_index <= tsc_pkg::CFG_ERROR_LIMIT;
        cfg_data  <= {4'($urandom), el};
        @(posedge clk);
        cfg_index <= tsc_pkg::CFG_STRAIGHT_LIMIT;
        cfg_data  <= sl;
        @(posedge clk);
        cfg_index <= tsc_pkg::CFG_TOP_LIMIT;
        cfg_data  <= {6'($urandom), tl};
        @(posedge clk);
        cfg_index <= tsc_pkg::CFG_FORESIGHT;
        cfg_data  <= {6'($urandom), fl};
        @(posedge clk);
        cfg_index <= tsc_pkg::CFG_PERIOD;
        cfg_data  <= {8'($urandom), per};
        @(posedge clk);
        cfg_we <= 1'b0;
        err_limit_now = int'(el);
    endtask

    // One frame: mostly a straight or sloped centre line with small noise, sometimes
    // pure noise; row count is full, short or too long.
    task automatic run_random_frame();
        int kind;
        int n_rows;
        int base;
        int slope;
        int amp;
        int r;
        int rp;
        int v;
        int t;
        int s;
        bit noisy;
        kind   = $urandom_range(0, 9);
        n_rows = (kind < 5) ? NUM_ROWS - 1 :
                 (kind < 8) ? $urandom_range(0, NUM_ROWS - 2) :
                              $urandom_range(NUM_ROWS, NUM_ROWS + 8);
        noisy  = ($urandom_range(0, 3) == 0);
        base   = $urandom_range(0, 79);
        slope  = int'($urandom_range(0, 128)) - 64;
        amp    = $urandom_range(0, 3);
        for (r = 0; r <= n_rows; r++) begin
            rp = (r == n_rows) ? NUM_ROWS - 1 : ((r < NUM_ROWS - 1) ? r : NUM_ROWS - 2);
            if (noisy) begin
                v = $urandom_range(0, 127);
            end else begin
                v = base + (slope * rp) / 32 + int'($urandom_range(0, amp));
                v = (v < 0) ? 0 : ((v > 79) ? 79 : v);
            end
            if (r < n_rows) begin
                send_row(v[tsc_pkg::CENTRE_W-1:0], 1'b0, tsc_pkg::TOP_W'($urandom),
                         tsc_pkg::STEER_W'($urandom), tsc_pkg::LOOK_W'($urandom));
            end
        end
        t = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_ROWS, 63)
                                       : $urandom_range(0, NUM_ROWS - 1);
        if ($urandom_range(0, 6) == 0) begin
            s = $urandom_range(0, 255);
        end else if ($urandom_range(0, 6) == 0) begin
            s = err_limit_now;
        end else if (steer_high) begin
            s = err_limit_now + int'($urandom_range(1, 30));
            s = (s > 255) ? 255 : s;
        end else begin
            s = err_limit_now - int'($urandom_range(1, 5));
            s = (s < 0) ? 0 : s;
        end
        // keep the steering trend for a few frames so the history settles
        if ($urandom_range(0, 3) == 0) begin
            steer_high = !steer_high;
        end
        send_row(v[tsc_pkg::CENTRE_W-1:0], 1'b1, t[tsc_pkg::TOP_W-1:0],
                 s[tsc_pkg::STEER_W-1:0], tsc_pkg::LOOK_W'($urandom));
    endtask

    task automatic run_phase(input int p);
        drain();
        case (p % 6)
            0: begin
                program_regs(8'd5, 12'd30, 6'd25, 6'd5, 4'd1);
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                program_regs(8'd0, 12'd0, 6'd0, 6'd0, 4'd15);
                send_idle_pct  = 80;
                recv_stall_pct = 0;
            end
            2: begin
                program_regs(8'd255, 12'd4095, 6'd59, 6'd59, 4'd1);
                send_idle_pct  = 0;
                recv_stall_pct = 80;
            end
            3: begin
                // zero period: push every sixteenth frame
                program_regs(8'($urandom_range(0, 40)), 12'($urandom_range(0, 300)),
                             6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)), 4'd0);
                send_idle_pct  = 18;
                recv_stall_pct = 18;
            end
            4: begin
                program_regs(8'($urandom_range(0, 40)), 12'($urandom_range(0, 300)),
                             6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
                             4'($urandom_range(1, 3)));
                send_idle_pct  = 18;
                recv_stall_pct = 18;
                hold_off_req   = 1'b1;
            end
            default: begin
                program_regs(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                             6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
                             4'($urandom_range(0, 15)));
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
        repeat (FRAMES_PER_PHASE) run_random_frame();
    endtask

    initial begin : stimulus
        int r;
        int p;
        logic [tsc_pkg::CENTRE_W-1:0] col;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        centre    <= '0;
        last_row  <= 1'b0;
        top_row   <= '0;
        steer     <= '0;
        look      <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= tsc_pkg::CFG_ERROR_LIMIT;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_regs(8'd5, 12'd4095, 6'd59, 6'd5, 4'd1);

        // Full first frame so every store entry the chord can read is written.
        for (r = 0; r < NUM_ROWS - 1; r++) begin
            case (r % 4)
                0: col = 7'd0;
                1: col = 7'd79;
                2: col = 7'd127;
                default: col = r[tsc_pkg::CENTRE_W-1:0];
            endcase
            send_row(col, 1'b0, 6'd63, 8'd255, 6'd63);
        end
        send_row(7'd0, 1'b1, 6'd0, 8'd255, 6'd59);

        // Single-row frames reuse the stored centres.
        send_row(7'd127, 1'b1, 6'd63, 8'd255, 6'd0);   // top row past the last row
        send_row(7'd80, 1'b1, 6'd59, 8'd255, 6'd0);
        send_row(7'd40, 1'b1, 6'd57, 8'd255, 6'd0);    // far row is the last row
        send_row(7'd79, 1'b1, 6'd56, 8'd255, 6'd0);
        send_row(7'd0, 1'b1, 6'd0, 8'd6, 6'd59);
        send_row(7'd1, 1'b1, 6'd10, 8'd0, 6'd0);
        send_row(7'd20, 1'b1, 6'd20, 8'd0, 6'd59);
        send_row(7'd30, 1'b1, 6'd30, 8'd0, 6'd5);
        send_row(7'd50, 1'b1, 6'd40, 8'd0, 6'd6);
        send_row(7'd60, 1'b1, 6'd2, 8'd4, 6'd0);
        // history entries equal to the limit
        send_row(7'd70, 1'b1, 6'd3, 8'd5, 6'd0);
        send_row(7'd10, 1'b1, 6'd4, 8'd5, 6'd0);
        send_row(7'd5, 1'b1, 6'd5, 8'd5, 6'd0);

        p = 0;
        while (items_sent < ITEM_TARGET || frames_sent < FRAME_TARGET) begin
            run_phase(p);
            p++;
        end

        drain();
        if (chk_fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ track_straightness_classifier_core.f @@
+incdir+hw/rtl
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_ram.sv
hw/rtl/tsc_ctrl.sv
hw/rtl/tsc_datapath.sv
hw/rtl/track_straightness_classifier_core.sv
verif/track_straightness_classifier_checker.sv
verif/tb_track_straightness_classifier_core.sv
